// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the address decode RTL.
// Each macro checks on the rising clock edge and is switched off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication property on every clock edge out of reset.
`define ASSERT_PROP(label, clk_i, rst_ni, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds on a clock edge out of reset.
`define ASSERT_NEVER(label, clk_i, rst_ni, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/x86msad_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ModR/M and SIB address decoder: field codes and transaction types.
// It depends on nothing else.
package x86msad_pkg;

  localparam logic       OP_WRITE     = 1'b0;
  localparam logic       OP_DECODE    = 1'b1;
  localparam logic [1:0] MOD_NO_DISP  = 2'd0;
  localparam logic [1:0] MOD_DISP8    = 2'd1;
  localparam logic [1:0] MOD_DISP32   = 2'd2;
  localparam logic [1:0] MOD_REGISTER = 2'd3;
  localparam logic [2:0] RM_SIB       = 3'd4;
  localparam logic [2:0] BASE_DISP32  = 3'd5;
  localparam logic [2:0] INDEX_NONE   = 3'd4;
  localparam logic [1:0] WIDTH_BYTE   = 2'd0;
  localparam logic [1:0] WIDTH_WORD   = 2'd1;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 112;

  typedef struct packed {
    logic        operation;
    logic [2:0]  write_index;
    logic [31:0] write_value;
    logic [7:0]  modrm_byte;
    logic [7:0]  sib_byte;
    logic [31:0] disp_bytes;
    logic [1:0]  reg_width;
    logic [1:0]  rm_width;
    logic        want_reg_value;
    logic        want_rm_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  reg_number;
    logic        rm_is_register;
    logic [2:0]  rm_number;
    logic [31:0] effective_address;
    logic [2:0]  bytes_consumed;
    logic [31:0] reg_value;
    logic [31:0] rm_value;
    logic        needs_load;
  } result_t;

endpackage

// ===== hdl/x86_modrm_sib_address_decode.sv =====
`timescale 1ns / 1ps
// Top level of the ModR/M and SIB effective address decoder with its register file.
// It depends on x86msad_pkg and on assert_macros.svh.

// The block holds eight 32-bit general registers and decodes 32-bit ModR/M and SIB
// addressing. A transaction with tuser low writes a register and gives no result; one with
// tuser high gives one result with the reg field, the register or memory form, the effective
// address, the bytes consumed and the requested register values. One transaction is accepted
// every clock cycle unless a decode waits in the input register behind a result not taken;
// a decode passes the input register, then the three-operand address adder behind the
// register file read, into the result register. A write is seen by every later transaction.

module x86_modrm_sib_address_decode (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // write_index, write_value, modrm_byte, sib_byte, disp_bytes, reg_width, rm_width,
  // want_reg_value, want_rm_value, then zero padding
  input  logic [x86msad_pkg::IN_DATA_W-1:0]   in_tdata,
  // operation
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // reg_number, rm_number, effective_address, bytes_consumed, reg_value, rm_value,
  // needs_load, then zero padding
  output logic [x86msad_pkg::OUT_DATA_W-1:0]  out_tdata,
  // rm_is_register
  output logic                                out_tuser
);

  import x86msad_pkg::*;

  `include "assert_macros.svh"

  logic [31:0] gpr_r [8];
  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        out_valid_r;
  result_t     res_r;
  result_t     res_nxt;
  in_item_t    in_item;
  logic        advance;

  logic [1:0]  mod_f;
  logic [2:0]  reg_f;
  logic [2:0]  rm_f;
  logic        is_reg;
  logic        has_sib;
  logic [2:0]  base_f;
  logic [2:0]  index_f;
  logic [1:0]  scale_f;
  logic        has_base;
  logic        has_index;
  logic [31:0] disp;
  logic [2:0]  disp_len;
  logic [31:0] base_val;
  logic [31:0] index_val;

  function automatic logic [31:0] read_gpr(input logic [31:0] regs [8],
                                           input logic [2:0] num,
                                           input logic [1:0] width);
    logic [31:0] v;
    begin
      v = regs[{1'b0, num[1:0]}];
      case (width)
        WIDTH_BYTE: begin
          read_gpr = num[2] ? {24'd0, v[15:8]} : {24'd0, v[7:0]};
        end
        WIDTH_WORD: begin
          read_gpr = {16'd0, regs[num][15:0]};
        end
        default: begin
          read_gpr = regs[num];
        end
      endcase
    end
  endfunction

  assign in_item.operation      = in_tuser;
  assign in_item.write_index    = in_tdata[2:0];
  assign in_item.write_value    = in_tdata[34:3];
  assign in_item.modrm_byte     = in_tdata[42:35];
  assign in_item.sib_byte       = in_tdata[50:43];
  assign in_item.disp_bytes     = in_tdata[82:51];
  assign in_item.reg_width      = in_tdata[84:83];
  assign in_item.rm_width       = in_tdata[86:85];
  assign in_item.want_reg_value = in_tdata[87];
  assign in_item.want_rm_value  = in_tdata[88];

  assign advance   = !s1_valid_r || (s1_item_r.operation == OP_WRITE) || !out_valid_r
                     || out_tready;
  assign in_tready = advance;

  always_comb begin
    mod_f    = s1_item_r.modrm_byte[7:6];
    reg_f    = s1_item_r.modrm_byte[5:3];
    rm_f     = s1_item_r.modrm_byte[2:0];
    is_reg   = (mod_f == MOD_REGISTER);
    has_sib  = !is_reg && (rm_f == RM_SIB);
    base_f   = has_sib ? s1_item_r.sib_byte[2:0] : rm_f;
    index_f  = s1_item_r.sib_byte[5:3];
    scale_f  = s1_item_r.sib_byte[7:6];
    has_index = has_sib && (index_f != INDEX_NONE);
    has_base  = 1'b1;
    disp      = 32'd0;
    disp_len  = 3'd0;
    case (mod_f)
      MOD_NO_DISP: begin
        if (base_f == BASE_DISP32) begin
          has_base = 1'b0;
          disp     = s1_item_r.disp_bytes;
          disp_len = 3'd4;
        end
      end
      MOD_DISP8: begin
        disp     = {{24{s1_item_r.disp_bytes[7]}}, s1_item_r.disp_bytes[7:0]};
        disp_len = 3'd1;
      end
      MOD_DISP32: begin
        disp     = s1_item_r.disp_bytes;
        disp_len = 3'd4;
      end
      default: begin
        disp     = 32'd0;
        disp_len = 3'd0;
      end
    endcase
    base_val  = has_base ? gpr_r[base_f] : 32'd0;
    index_val = has_index ? (gpr_r[index_f] << scale_f) : 32'd0;

    res_nxt.reg_number     = reg_f;
    res_nxt.rm_is_register = is_reg;
    res_nxt.rm_number      = is_reg ? rm_f : 3'd0;
    res_nxt.effective_address = is_reg ? 32'd0 : (disp + base_val + index_val);
    res_nxt.bytes_consumed = is_reg ? 3'd1 : (3'd1 + {2'd0, has_sib} + disp_len);
    res_nxt.reg_value      = s1_item_r.want_reg_value
                             ? read_gpr(gpr_r, reg_f, s1_item_r.reg_width) : 32'd0;
    res_nxt.rm_value       = (is_reg && s1_item_r.want_rm_value)
                             ? read_gpr(gpr_r, rm_f, s1_item_r.rm_width) : 32'd0;
    res_nxt.needs_load     = !is_reg && s1_item_r.want_rm_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        gpr_r[i] <= 32'd0;
      end
    end else begin
      if (advance) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_valid_r && advance && (s1_item_r.operation == OP_WRITE)) begin
        gpr_r[s1_item_r.write_index] <= s1_item_r.write_value;
      end
      if (advance) begin
        if (s1_valid_r && (s1_item_r.operation == OP_DECODE)) begin
          out_valid_r <= 1'b1;
        end else if (out_tready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_tvalid) begin
      s1_item_r <= in_item;
    end
    if (advance && s1_valid_r && (s1_item_r.operation == OP_DECODE)) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.rm_is_register;
  assign out_tdata  = {6'd0, res_r.needs_load, res_r.rm_value, res_r.reg_value,
                       res_r.bytes_consumed, res_r.effective_address, res_r.rm_number,
                       res_r.reg_number};

  `ASSERT_PROP(a_result_from_decode, clk, rst_n,
    $rose(out_valid_r) |-> $past(s1_valid_r && (s1_item_r.operation == OP_DECODE)),
    "Result appeared without a decode transaction in the input register.")
  `ASSERT_NEVER(a_bytes_in_range, clk, rst_n,
    out_valid_r && ((res_r.bytes_consumed == 3'd0) || (res_r.bytes_consumed == 3'd7)),
    "Bytes consumed out of range.")
  `ASSERT_PROP(a_register_form, clk, rst_n,
    (out_valid_r && res_r.rm_is_register) |->
      ((res_r.effective_address == 32'd0) && (res_r.bytes_consumed == 3'd1)
       && !res_r.needs_load),
    "Register form result carries memory form fields.")
  `ASSERT_PROP(a_memory_form, clk, rst_n,
    (out_valid_r && !res_r.rm_is_register) |->
      ((res_r.rm_number == 3'd0) && (res_r.rm_value == 32'd0)),
    "Memory form result carries a register operand.")

endmodule
